### rtl/stl_pkg.sv
`default_nettype none
package stl_pkg;

    localparam int OFFSET_BITS   = 20;
    localparam int POSITION_BITS = 16;
    localparam int KEYWORD_CHARS = 8;
    localparam int CNT_BITS      = 4;
    localparam int NUM_KW        = 18;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    localparam logic [5:0] K_NOT    = 6'd15;
    localparam logic [5:0] K_IDENT  = 6'd18;
    localparam logic [5:0] K_NUMBER = 6'd19;
    localparam logic [5:0] K_STRING = 6'd20;
    localparam logic [5:0] K_LPAREN = 6'd21;
    localparam logic [5:0] K_RPAREN = 6'd22;
    localparam logic [5:0] K_LBRACE = 6'd23;
    localparam logic [5:0] K_RBRACE = 6'd24;
    localparam logic [5:0] K_COLON  = 6'd25;
    localparam logic [5:0] K_COMMA  = 6'd26;
    localparam logic [5:0] K_SEMI   = 6'd27;
    localparam logic [5:0] K_DOT    = 6'd28;
    localparam logic [5:0] K_PLUS   = 6'd29;
    localparam logic [5:0] K_MINUS  = 6'd30;
    localparam logic [5:0] K_STAR   = 6'd31;
    localparam logic [5:0] K_SLASH  = 6'd32;
    localparam logic [5:0] K_ASSIGN = 6'd33;
    localparam logic [5:0] K_EQEQ   = 6'd34;
    localparam logic [5:0] K_NEQ    = 6'd35;
    localparam logic [5:0] K_LT     = 6'd36;
    localparam logic [5:0] K_LE     = 6'd37;
    localparam logic [5:0] K_GT     = 6'd38;
    localparam logic [5:0] K_GE     = 6'd39;
    localparam logic [5:0] K_END    = 6'd40;
    localparam logic [5:0] K_ERROR  = 6'd41;

    localparam logic [1:0] E_NONE  = 2'd0;
    localparam logic [1:0] E_UNEXP = 2'd1;
    localparam logic [1:0] E_UNTERM = 2'd2;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_INT, M_DOT, M_FRAC, M_STR, M_SLASH, M_COMMENT,
        M_EQ, M_BANG, M_LT, M_GT
    } mode_t;

    typedef struct packed {
        logic [5:0]               kind;
        logic [1:0]               err;
        logic [OFFSET_BITS-1:0]   start;
        logic [OFFSET_BITS-1:0]   len;
        logic [POSITION_BITS-1:0] line;
        logic [POSITION_BITS-1:0] col;
    } token_t;

    typedef logic [KEYWORD_CHARS*8-1:0] name_t;

    function automatic logic [KEYWORD_CHARS*8-1:0] kw_text(input int k);
        logic [KEYWORD_CHARS*8-1:0] t;
        t = '0;
        case (k)
            0:  t[31:0] = {"m", "o", "o", "r"};
            1:  t[31:0] = {"m", "e", "t", "i"};
            2:  t[23:0] = {"r", "a", "v"};
            3:  t[63:0] = {"n", "o", "i", "t", "c", "n", "u", "f"};
            4:  t[15:0] = {"f", "i"};
            5:  t[31:0] = {"e", "s", "l", "e"};
            6:  t[39:0] = {"e", "l", "i", "h", "w"};
            7:  t[23:0] = {"r", "o", "f"};
            8:  t[47:0] = {"n", "r", "u", "t", "e", "r"};
            9:  t[31:0] = {"n", "e", "h", "w"};
            10: t[55:0] = {"d", "e", "r", "e", "t", "n", "e"};
            11: t[23:0] = {"y", "a", "s"};
            12: t[31:0] = {"o", "t", "o", "g"};
            13: t[31:0] = {"e", "u", "r", "t"};
            14: t[39:0] = {"e", "s", "l", "a", "f"};
            15: t[23:0] = {"t", "o", "n"};
            16: t[23:0] = {"d", "n", "a"};
            default: t[15:0] = {"r", "o"};
        endcase
        return t;
    endfunction

    function automatic logic [CNT_BITS-1:0] kw_len(input int k);
        case (k)
            0, 1, 5, 9, 12, 13: return CNT_BITS'(4);
            2, 7, 11, 15, 16:   return CNT_BITS'(3);
            3:                  return CNT_BITS'(8);
            4, 17:              return CNT_BITS'(2);
            6, 14:              return CNT_BITS'(5);
            8:                  return CNT_BITS'(6);
            default:            return CNT_BITS'(7);
        endcase
    endfunction

endpackage
`default_nettype wire

### rtl/stl_keyword_match.sv
`default_nettype none
module stl_keyword_match (
    input  wire stl_pkg::name_t                 name,
    input  wire logic [stl_pkg::CNT_BITS-1:0]   count,
    output logic [5:0]                          kind
);
    // bytes above count are masked so stale buffer entries do not matter
    always_comb begin
        logic [stl_pkg::KEYWORD_CHARS*8-1:0] mask;
        mask = '0;
        for (int i = 0; i < stl_pkg::KEYWORD_CHARS; i++) begin
            if (i < int'(count)) begin
                mask[i*8 +: 8] = 8'hff;
            end
        end
        kind = stl_pkg::K_IDENT;
        for (int k = stl_pkg::NUM_KW - 1; k >= 0; k--) begin
            if (count == stl_pkg::kw_len(k) && (name & mask) == stl_pkg::kw_text(k)) begin
                kind = 6'(k);
            end
        end
    end
endmodule
`default_nettype wire

### rtl/source_token_lexer_core.sv
`default_nettype none
// channel | dir | tdata (low bit up)                            | tuser              | tlast
// s_      | in  | char_byte[7:0]                                | end_of_source      | -
// m_      | out | start[19:0] len[39:20] line[55:40] col[71:56] | kind[5:0] err[7:6] | last_of_run
// one byte is taken per cycle while s_tready is high and is scanned in that cycle; its
// up to three tokens go into a three-entry result queue that drains one word per cycle
// s_tready is high while the queue is empty or holds only the word now leaving,
// so a byte with one token each streams at one per cycle
// aresetn is synchronous, active low; scan state returns to idle, line and column to one
// a stall on m_tready holds the queue and keeps s_tready low until its last word leaves
module source_token_lexer_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // char_byte
    input  wire logic        s_tuser,   // end_of_source
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // start, len, line, col
    output logic [7:0]       m_tuser,   // kind, err
    output logic             m_tlast    // last_of_run
);
    localparam int OB = stl_pkg::OFFSET_BITS;
    localparam int PB = stl_pkg::POSITION_BITS;
    localparam int CB = stl_pkg::CNT_BITS;

    stl_pkg::mode_t         mode_reg, mode_next;
    logic [7:0]             nbuf_reg [stl_pkg::KEYWORD_CHARS];
    logic [CB-1:0]          cnt_reg, cnt_next;
    logic [OB-1:0]          off_reg, tstart_reg, tstart_next;
    logic [PB-1:0]          line_reg, col_reg, sline_reg, scol_reg, sline_next, scol_next;

    stl_pkg::token_t        q_reg [3];
    logic                   ql_reg [3];
    logic [1:0]             qn_reg;

    stl_pkg::token_t        tok [3];
    logic [1:0]             ntok;
    logic                   wr_en;
    logic [CB-1:0]          wr_idx;
    logic [5:0]             nkind;
    stl_pkg::name_t         name_flat;

    logic                   s_acc, m_acc;

    assign m_acc    = m_tvalid && m_tready;
    assign s_tready = (qn_reg == 2'd0) || (qn_reg == 2'd1 && m_tready);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = qn_reg != 2'd0;
    assign m_tdata  = {q_reg[0].col, q_reg[0].line, q_reg[0].len, q_reg[0].start};
    assign m_tuser  = {q_reg[0].err, q_reg[0].kind};
    assign m_tlast  = ql_reg[0];

    always_comb begin
        for (int i = 0; i < stl_pkg::KEYWORD_CHARS; i++) begin
            name_flat[i*8 +: 8] = nbuf_reg[i];
        end
    end

    stl_keyword_match u_kw (.name(name_flat), .count(cnt_reg), .kind(nkind));

    always_comb begin
        logic [7:0]    c;
        logic          alpha, digit, rescan;
        logic [OB-1:0] dot_off;
        logic [5:0]    p1, p2;
        stl_pkg::token_t pend;
        c      = s_tdata;
        alpha  = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        digit  = c >= "0" && c <= "9";
        mode_next   = mode_reg;
        cnt_next    = cnt_reg;
        tstart_next = tstart_reg;
        sline_next  = sline_reg;
        scol_next   = scol_reg;
        wr_en  = 1'b0;
        wr_idx = cnt_reg;
        ntok   = 2'd0;
        for (int i = 0; i < 3; i++) begin
            tok[i] = '0;
        end
        rescan  = 1'b0;
        dot_off = off_reg - OB'(1);
        pend.kind  = stl_pkg::K_NUMBER;
        pend.err   = stl_pkg::E_NONE;
        pend.start = tstart_reg;
        pend.len   = off_reg - tstart_reg;
        pend.line  = sline_reg;
        pend.col   = scol_reg;
        unique case (mode_reg)
            stl_pkg::M_EQ:   begin p1 = stl_pkg::K_ASSIGN; p2 = stl_pkg::K_EQEQ; end
            stl_pkg::M_BANG: begin p1 = stl_pkg::K_NOT;    p2 = stl_pkg::K_NEQ;  end
            stl_pkg::M_LT:   begin p1 = stl_pkg::K_LT;     p2 = stl_pkg::K_LE;   end
            default:         begin p1 = stl_pkg::K_GT;     p2 = stl_pkg::K_GE;   end
        endcase
        if (s_tuser) begin
            unique case (mode_reg)
                stl_pkg::M_IDENT: begin
                    pend.kind = nkind; tok[0] = pend; ntok = 2'd1;
                end
                stl_pkg::M_INT, stl_pkg::M_FRAC: begin tok[0] = pend; ntok = 2'd1; end
                stl_pkg::M_DOT: begin
                    tok[0] = pend; tok[0].len = dot_off - tstart_reg;
                    tok[1] = '{stl_pkg::K_DOT, stl_pkg::E_NONE, dot_off, OB'(1), line_reg,
                               (col_reg == stl_pkg::POS_MAX) ? col_reg : col_reg - PB'(1)};
                    ntok = 2'd2;
                end
                stl_pkg::M_STR: begin
                    pend.kind = stl_pkg::K_ERROR; pend.err = stl_pkg::E_UNTERM;
                    tok[0] = pend; ntok = 2'd1;
                end
                stl_pkg::M_SLASH: begin
                    pend.kind = stl_pkg::K_SLASH; tok[0] = pend; ntok = 2'd1;
                end
                stl_pkg::M_EQ, stl_pkg::M_BANG, stl_pkg::M_LT, stl_pkg::M_GT: begin
                    pend.kind = p1; tok[0] = pend; ntok = 2'd1;
                end
                default: ;
            endcase
            tok[ntok] = '{stl_pkg::K_END, stl_pkg::E_NONE, off_reg, '0, line_reg, col_reg};
            ntok = ntok + 2'd1;
            mode_next   = stl_pkg::M_IDLE;
            cnt_next    = '0;
            tstart_next = '0;
            sline_next  = PB'(1);
            scol_next   = PB'(1);
        end else begin
            unique case (mode_reg)
                stl_pkg::M_IDLE: rescan = 1'b1;
                stl_pkg::M_IDENT: begin
                    if (alpha || digit) begin
                        if (cnt_reg < CB'(stl_pkg::KEYWORD_CHARS)) begin
                            wr_en = 1'b1;
                            cnt_next = cnt_reg + CB'(1);
                        end else begin
                            cnt_next = CB'(stl_pkg::KEYWORD_CHARS + 1);
                        end
                    end else begin
                        pend.kind = nkind; tok[0] = pend; ntok = 2'd1; rescan = 1'b1;
                    end
                end
                stl_pkg::M_INT: begin
                    if (c == ".") mode_next = stl_pkg::M_DOT;
                    else if (!digit) begin tok[0] = pend; ntok = 2'd1; rescan = 1'b1; end
                end
                stl_pkg::M_DOT: begin
                    if (digit) mode_next = stl_pkg::M_FRAC;
                    else begin
                        tok[0] = pend; tok[0].len = dot_off - tstart_reg;
                        tok[1] = '{stl_pkg::K_DOT, stl_pkg::E_NONE, dot_off, OB'(1), line_reg,
                                   (col_reg == stl_pkg::POS_MAX) ? col_reg : col_reg - PB'(1)};
                        ntok = 2'd2; rescan = 1'b1;
                    end
                end
                stl_pkg::M_FRAC: begin
                    if (!digit) begin tok[0] = pend; ntok = 2'd1; rescan = 1'b1; end
                end
                stl_pkg::M_STR: begin
                    if (c == "\"") begin
                        pend.kind = stl_pkg::K_STRING;
                        pend.len  = off_reg + OB'(1) - tstart_reg;
                        tok[0] = pend; ntok = 2'd1; mode_next = stl_pkg::M_IDLE;
                    end
                end
                stl_pkg::M_SLASH: begin
                    if (c == "/") mode_next = stl_pkg::M_COMMENT;
                    else begin
                        pend.kind = stl_pkg::K_SLASH; tok[0] = pend; ntok = 2'd1; rescan = 1'b1;
                    end
                end
                stl_pkg::M_COMMENT: begin
                    if (c == 8'h0a) rescan = 1'b1;
                end
                default: begin
                    if (c == "=") begin
                        pend.kind = p2; pend.len = off_reg + OB'(1) - tstart_reg;
                        tok[0] = pend; ntok = 2'd1; mode_next = stl_pkg::M_IDLE;
                    end else begin
                        pend.kind = p1; tok[0] = pend; ntok = 2'd1; rescan = 1'b1;
                    end
                end
            endcase
            if (rescan) begin
                mode_next   = stl_pkg::M_IDLE;
                tstart_next = off_reg;
                sline_next  = line_reg;
                scol_next   = col_reg;
                if (alpha) begin
                    mode_next = stl_pkg::M_IDENT; wr_en = 1'b1; wr_idx = '0; cnt_next = CB'(1);
                end else if (digit) mode_next = stl_pkg::M_INT;
                else begin
                    case (c)
                        " ", 8'h09, 8'h0d, 8'h0a: ;
                        "/":  mode_next = stl_pkg::M_SLASH;
                        "\"": mode_next = stl_pkg::M_STR;
                        "=":  mode_next = stl_pkg::M_EQ;
                        "!":  mode_next = stl_pkg::M_BANG;
                        "<":  mode_next = stl_pkg::M_LT;
                        ">":  mode_next = stl_pkg::M_GT;
                        "(", ")", "{", "}", ":", ",", ";", ".", "+", "-", "*": begin
                            tok[ntok] = '{stl_pkg::K_LPAREN, stl_pkg::E_NONE, off_reg, OB'(1),
                                          line_reg, col_reg};
                            case (c)
                                ")": tok[ntok].kind = stl_pkg::K_RPAREN;
                                "{": tok[ntok].kind = stl_pkg::K_LBRACE;
                                "}": tok[ntok].kind = stl_pkg::K_RBRACE;
                                ":": tok[ntok].kind = stl_pkg::K_COLON;
                                ",": tok[ntok].kind = stl_pkg::K_COMMA;
                                ";": tok[ntok].kind = stl_pkg::K_SEMI;
                                ".": tok[ntok].kind = stl_pkg::K_DOT;
                                "+": tok[ntok].kind = stl_pkg::K_PLUS;
                                "-": tok[ntok].kind = stl_pkg::K_MINUS;
                                "*": tok[ntok].kind = stl_pkg::K_STAR;
                                default: ;
                            endcase
                            ntok = ntok + 2'd1;
                        end
                        default: begin
                            tok[ntok] = '{stl_pkg::K_ERROR, stl_pkg::E_UNEXP, off_reg, OB'(1),
                                          line_reg, col_reg};
                            ntok = ntok + 2'd1;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && !s_tuser && wr_en) begin
            nbuf_reg[wr_idx[2:0]] <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= stl_pkg::M_IDLE;
            cnt_reg    <= '0;
            off_reg    <= '0;
            tstart_reg <= '0;
            line_reg   <= PB'(1);
            col_reg    <= PB'(1);
            sline_reg  <= PB'(1);
            scol_reg   <= PB'(1);
            qn_reg     <= '0;
        end else begin
            if (s_acc) begin
                mode_reg   <= mode_next;
                cnt_reg    <= cnt_next;
                tstart_reg <= tstart_next;
                sline_reg  <= sline_next;
                scol_reg   <= scol_next;
                if (s_tuser) begin
                    off_reg  <= '0;
                    line_reg <= PB'(1);
                    col_reg  <= PB'(1);
                end else begin
                    off_reg <= off_reg + OB'(1);
                    if (s_tdata == 8'h0a) begin
                        if (line_reg != stl_pkg::POS_MAX) line_reg <= line_reg + PB'(1);
                        col_reg <= PB'(1);
                    end else if (col_reg != stl_pkg::POS_MAX) begin
                        col_reg <= col_reg + PB'(1);
                    end
                end
                // queue is empty or its only word leaves now
                qn_reg <= ntok;
                for (int i = 0; i < 3; i++) begin
                    q_reg[i]  <= tok[i];
                    ql_reg[i] <= (2'(i) == ntok - 2'd1);
                end
            end else if (m_acc) begin
                qn_reg   <= qn_reg - 2'd1;
                q_reg[0] <= q_reg[1];
                q_reg[1] <= q_reg[2];
                ql_reg[0] <= ql_reg[1];
                ql_reg[1] <= ql_reg[2];
            end
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CB'(stl_pkg::KEYWORD_CHARS + 1))
        else $error("name count out of range");
    a_q_depth: assert property (@(posedge aclk) disable iff (!aresetn) qn_reg != 2'd3 ||
        !s_tready) else $error("ready with full queue");
    a_tail_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (qn_reg == 2'd1) |-> m_tlast) else $error("last word missing tlast");
    a_idle_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser) |=> (mode_reg == stl_pkg::M_IDLE && off_reg == '0))
        else $error("no restart after end");
endmodule
`default_nettype wire

### test/source_token_lexer_core_test.sv
module source_token_lexer_core_test;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [19:0] start;
        logic [19:0] len;
        logic [15:0] line;
        logic [15:0] col;
        logic        last;
    } token_rec_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [7:0]  m_tuser;
    logic        m_tlast;

    source_token_lexer_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    token_rec_t  token_q[$];
    token_rec_t  run_toks[3];
    int          run_n;
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          quiet_send = 0;
    bit          quiet_recv = 0;

    stl_pkg::mode_t lex_mode;
    logic [7:0]  name_buf[8];
    logic [3:0]  name_cnt;
    logic [19:0] byte_off;
    logic [19:0] tok_start;
    logic [15:0] cur_line;
    logic [15:0] cur_col;
    logic [15:0] tok_line;
    logic [15:0] tok_col;

    string kw_words[18] = '{"room", "item", "var", "function", "if", "else", "while", "for",
        "return", "when", "entered", "say", "goto", "true", "false", "not", "and", "or"};
    string single_ops = "(){}:,;.+-*";

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic clear_lexer();
        lex_mode = stl_pkg::M_IDLE;
        name_cnt = '0;
        byte_off = '0;
        tok_start = '0;
        cur_line = 16'd1;
        cur_col = 16'd1;
        tok_line = 16'd1;
        tok_col = 16'd1;
    endtask

    task automatic add_token(logic [5:0] kind, logic [1:0] err, logic [19:0] start,
                             logic [19:0] len, logic [15:0] line, logic [15:0] col);
        if (run_n < 3) begin
            run_toks[run_n] = '{kind, err, start, len, line, col, 1'b0};
            run_n++;
        end
    endtask

    task automatic add_pending(logic [5:0] kind, logic [1:0] err);
        add_token(kind, err, tok_start, byte_off - tok_start, tok_line, tok_col);
    endtask

    function automatic logic [5:0] name_token_kind();
        bit same;
        if (name_cnt > stl_pkg::KEYWORD_CHARS) return stl_pkg::K_IDENT;
        for (int k = 0; k < 18; k++) begin
            if (kw_words[k].len() == name_cnt) begin
                same = 1;
                for (int i = 0; i < name_cnt; i++)
                    if (kw_words[k][i] != name_buf[i]) same = 0;
                if (same) return 6'(k);
            end
        end
        return stl_pkg::K_IDENT;
    endfunction

    task automatic add_number_and_dot();
        logic [19:0] dot_off;
        logic [15:0] dot_col;
        dot_off = byte_off - 20'd1;
        dot_col = (cur_col == stl_pkg::POS_MAX) ? stl_pkg::POS_MAX : cur_col - 16'd1;
        add_token(stl_pkg::K_NUMBER, stl_pkg::E_NONE, tok_start, dot_off - tok_start,
                  tok_line, tok_col);
        add_token(stl_pkg::K_DOT, stl_pkg::E_NONE, dot_off, 20'd1, cur_line, dot_col);
    endtask

    function automatic logic [5:0] one_char_kind(stl_pkg::mode_t m);
        case (m)
            stl_pkg::M_EQ:   return stl_pkg::K_ASSIGN;
            stl_pkg::M_BANG: return stl_pkg::K_NOT;
            stl_pkg::M_LT:   return stl_pkg::K_LT;
            default:         return stl_pkg::K_GT;
        endcase
    endfunction

    function automatic logic [5:0] two_char_kind(stl_pkg::mode_t m);
        case (m)
            stl_pkg::M_EQ:   return stl_pkg::K_EQEQ;
            stl_pkg::M_BANG: return stl_pkg::K_NEQ;
            stl_pkg::M_LT:   return stl_pkg::K_LE;
            default:         return stl_pkg::K_GE;
        endcase
    endfunction

    task automatic start_token(logic [7:0] c);
        tok_start = byte_off;
        tok_line = cur_line;
        tok_col = cur_col;
        if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) return;
        if (is_alpha(c)) begin
            name_buf[0] = c;
            name_cnt = 4'd1;
            lex_mode = stl_pkg::M_IDENT;
            return;
        end
        if (is_digit(c)) begin
            lex_mode = stl_pkg::M_INT;
            return;
        end
        for (int k = 0; k < 11; k++) begin
            if (single_ops[k] == c) begin
                add_token(stl_pkg::K_LPAREN + 6'(k), stl_pkg::E_NONE, byte_off, 20'd1,
                          cur_line, cur_col);
                return;
            end
        end
        case (c)
            "/": lex_mode = stl_pkg::M_SLASH;
            8'h22: lex_mode = stl_pkg::M_STR;
            "=": lex_mode = stl_pkg::M_EQ;
            "!": lex_mode = stl_pkg::M_BANG;
            "<": lex_mode = stl_pkg::M_LT;
            ">": lex_mode = stl_pkg::M_GT;
            default: add_token(stl_pkg::K_ERROR, stl_pkg::E_UNEXP, byte_off, 20'd1,
                               cur_line, cur_col);
        endcase
    endtask

    task automatic continue_token(logic [7:0] c, output bit rescan);
        rescan = 0;
        case (lex_mode)
            stl_pkg::M_IDENT: begin
                if (is_alpha(c) || is_digit(c)) begin
                    if (name_cnt < stl_pkg::KEYWORD_CHARS) begin
                        name_buf[name_cnt] = c;
                        name_cnt++;
                    end else begin
                        name_cnt = 4'(stl_pkg::KEYWORD_CHARS + 1);
                    end
                    return;
                end
                add_pending(name_token_kind(), stl_pkg::E_NONE);
            end
            stl_pkg::M_INT: begin
                if (is_digit(c)) return;
                if (c == ".") begin
                    lex_mode = stl_pkg::M_DOT;
                    return;
                end
                add_pending(stl_pkg::K_NUMBER, stl_pkg::E_NONE);
            end
            stl_pkg::M_DOT: begin
                if (is_digit(c)) begin
                    lex_mode = stl_pkg::M_FRAC;
                    return;
                end
                add_number_and_dot();
            end
            stl_pkg::M_FRAC: begin
                if (is_digit(c)) return;
                add_pending(stl_pkg::K_NUMBER, stl_pkg::E_NONE);
            end
            stl_pkg::M_STR: begin
                if (c == 8'h22) begin
                    add_token(stl_pkg::K_STRING, stl_pkg::E_NONE, tok_start,
                              byte_off + 20'd1 - tok_start, tok_line, tok_col);
                    lex_mode = stl_pkg::M_IDLE;
                end
                return;
            end
            stl_pkg::M_SLASH: begin
                if (c == "/") begin
                    lex_mode = stl_pkg::M_COMMENT;
                    return;
                end
                add_pending(stl_pkg::K_SLASH, stl_pkg::E_NONE);
            end
            stl_pkg::M_COMMENT: begin
                if (c != 8'h0a) return;
            end
            default: begin
                if (c == "=") begin
                    add_token(two_char_kind(lex_mode), stl_pkg::E_NONE, tok_start,
                              byte_off + 20'd1 - tok_start, tok_line, tok_col);
                    lex_mode = stl_pkg::M_IDLE;
                    return;
                end
                add_pending(one_char_kind(lex_mode), stl_pkg::E_NONE);
            end
        endcase
        lex_mode = stl_pkg::M_IDLE;
        rescan = 1;
    endtask

    task automatic predict_tokens(logic [7:0] c, logic eos);
        bit rescan;
        run_n = 0;
        if (eos) begin
            case (lex_mode)
                stl_pkg::M_IDENT: add_pending(name_token_kind(), stl_pkg::E_NONE);
                stl_pkg::M_INT, stl_pkg::M_FRAC: add_pending(stl_pkg::K_NUMBER, stl_pkg::E_NONE);
                stl_pkg::M_DOT: add_number_and_dot();
                stl_pkg::M_STR: add_pending(stl_pkg::K_ERROR, stl_pkg::E_UNTERM);
                stl_pkg::M_SLASH: add_pending(stl_pkg::K_SLASH, stl_pkg::E_NONE);
                stl_pkg::M_EQ, stl_pkg::M_BANG, stl_pkg::M_LT, stl_pkg::M_GT:
                    add_pending(one_char_kind(lex_mode), stl_pkg::E_NONE);
                default: ;
            endcase
            add_token(stl_pkg::K_END, stl_pkg::E_NONE, byte_off, 20'd0, cur_line, cur_col);
            clear_lexer();
        end else begin
            rescan = 1;
            if (lex_mode != stl_pkg::M_IDLE) continue_token(c, rescan);
            if (rescan) start_token(c);
            byte_off++;
            if (c == 8'h0a) begin
                if (cur_line != stl_pkg::POS_MAX) cur_line++;
                cur_col = 16'd1;
            end else if (cur_col != stl_pkg::POS_MAX) begin
                cur_col++;
            end
        end
        for (int i = 0; i < run_n; i++) begin
            run_toks[i].last = (i == run_n - 1);
            token_q.insert(token_q.size(), run_toks[i]);
        end
    endtask

    task automatic send_word(logic [7:0] c, logic eos);
        int gap;
        gap = quiet_send ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = c;
        s_tuser = eos;
        do @(posedge aclk); while (!s_tready);
        predict_tokens(c, eos);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_text(string txt);
        for (int i = 0; i < txt.len(); i++) send_word(txt[i], 1'b0);
    endtask

    task automatic send_end();
        send_word(8'($urandom), 1'b1);
    endtask

    initial begin
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (!quiet_recv && $urandom_range(0, 2) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        token_rec_t exp_tok;
        if (aresetn && m_tvalid && m_tready) begin
            if (token_q.size() == 0) begin
                $error("token with none expected: %h %h", m_tuser, m_tdata);
                fail_count++;
            end else begin
                exp_tok = token_q.pop_front();
                if (m_tuser[5:0] != exp_tok.kind) begin
                    $error("token_kind expected %0d actual %0d", exp_tok.kind, m_tuser[5:0]);
                    fail_count++;
                end
                if (m_tuser[7:6] != exp_tok.err) begin
                    $error("error_kind expected %0d actual %0d", exp_tok.err, m_tuser[7:6]);
                    fail_count++;
                end
                if (m_tdata[19:0] != exp_tok.start) begin
                    $error("start_offset expected %0d actual %0d", exp_tok.start, m_tdata[19:0]);
                    fail_count++;
                end
                if (m_tdata[39:20] != exp_tok.len) begin
                    $error("token_length expected %0d actual %0d", exp_tok.len, m_tdata[39:20]);
                    fail_count++;
                end
                if (m_tdata[55:40] != exp_tok.line) begin
                    $error("line_number expected %0d actual %0d", exp_tok.line, m_tdata[55:40]);
                    fail_count++;
                end
                if (m_tdata[71:56] != exp_tok.col) begin
                    $error("column_number expected %0d actual %0d", exp_tok.col,
                           m_tdata[71:56]);
                    fail_count++;
                end
                if (m_tlast != exp_tok.last) begin
                    $error("last_of_run expected %0d actual %0d", exp_tok.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_keywords();
        foreach (kw_words[k]) send_text({kw_words[k], " "});
        send_text("functionx iff Room _a9 ");
        send_end();
    endtask

    task automatic test_operators();
        send_text("(){}:,;.+-*/= == != ! < <= > >= !x=<");
        send_end();
        send_text("12.) 3.14 7 0.5. a//c x\n=");
        send_end();
        send_text("12.");
        send_end();
        send_text("/");
        send_end();
    endtask

    task automatic test_strings_errors();
        send_text("\"ab\ncd\" say \"x");
        send_word(8'h0a, 1'b0);
        send_end();
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(8'h80, 1'b0);
        send_text("@#");
        send_end();
    endtask

    task automatic send_fragment();
        string frag;
        case ($urandom_range(0, 11))
            0: frag = kw_words[$urandom_range(0, 17)];
            1: begin
                frag = "";
                repeat ($urandom_range(1, 11))
                    frag = {frag, string'($urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
                                                      : 8'($urandom_range("0", "9")))};
                frag = {"v", frag};
            end
            2: frag = $sformatf("%0d", $urandom_range(0, 9999));
            3: frag = $sformatf("%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 99));
            4: frag = $sformatf("%0d.", $urandom_range(0, 99));
            5: frag = "\"hi\nyo\"";
            6: frag = "// note\n";
            7: frag = string'(single_ops[$urandom_range(0, 10)]);
            8: begin
                case ($urandom_range(0, 3))
                    0: frag = "=";
                    1: frag = "!";
                    2: frag = "<";
                    default: frag = ">";
                endcase
                if ($urandom_range(0, 1)) frag = {frag, "="};
            end
            9: frag = "/";
            10: frag = "\"";
            default: frag = "";
        endcase
        send_text(frag);
        case ($urandom_range(0, 5))
            0: send_word(8'($urandom), 1'b0);
            1: send_word(8'h0a, 1'b0);
            2, 3: send_word(" ", 1'b0);
            default: ;
        endcase
    endtask

    task automatic test_random_text();
        int sent;
        sent = 0;
        while (sent < 230) begin
            quiet_send = ($urandom_range(0, 7) == 0);
            quiet_recv = ($urandom_range(0, 7) == 0);
            send_fragment();
            sent += 4;
            if ($urandom_range(0, 29) == 0) send_end();
        end
        quiet_send = 0;
        quiet_recv = 0;
        send_end();
    endtask

    task automatic test_drain_pause();
        send_text("a.b 1.2.3 ");
        wait (token_q.size() == 0);
        @(negedge aclk);
        send_text("x<=y");
        send_end();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = 1'b0;
        clear_lexer();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_keywords();
        test_operators();
        test_strings_errors();
        test_drain_pause();
        test_random_text();
        wait (token_q.size() == 0);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && token_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
